>>> rtl/core/hall_pump_speed_gauge_top_defines.svh
// Assertion macros for the hall pump speed gauge.
// Included by RTL files that check their own sequencing; expects aclk and aresetn in scope.
`ifndef HALL_PUMP_SPEED_GAUGE_TOP_DEFINES_SVH
`define HALL_PUMP_SPEED_GAUGE_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define HPSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define HPSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hpsg_pkg.sv
// Shared types and constants for the hall pump speed gauge.
// No dependencies; imported by every module of the block.
package hpsg_pkg;

    // Pump table geometry
    localparam int NUM_PUMPS = 4;
    localparam int PUMP_W    = 2;
    localparam int CNT_W     = 8;
    localparam int TICK_W    = 16;
    localparam int SPEED_W   = 16;

    // Configuration field widths and reset values
    localparam int TIMEOUT_W = 16;
    localparam int PERIOD_W  = 7;
    localparam int MASK_W    = 4;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd500;
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 7'd10;
    localparam logic [MASK_W-1:0]    MASK_RST    = 4'd2;

    // Speed arithmetic: 6000000 / (2 * period * (ba + ab))
    localparam int QUO_W   = 23;
    localparam int DEN_W   = 25;
    localparam int DCNT_W  = $clog2(QUO_W + 1);
    localparam logic [QUO_W-1:0]   RPM_SCALE = 23'd6000000;
    localparam logic [SPEED_W-2:0] SPEED_MAX = 15'h7FFF;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 8'hFF;
    localparam logic [TICK_W-1:0]  TICK_MAX  = 16'hFFFF;

    // APB register file
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_PERIOD  = 2'd1,
        REG_REVERSE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [PERIOD_W-1:0]  tick_period_ms;
        logic [MASK_W-1:0]    reverse_mask;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } gauge_state_t;

endpackage

>>> rtl/core/hall_pump_speed_gauge_top.sv
// Hall pump speed gauge: tick sequencer, per-pump edge tracking and speed measurement.
// Depends on hpsg_pkg, hpsg_regs, hpsg_div and the assertion macro header.
//
// Usage:
//   Each transfer on the s_ channel is one timer tick for one pump, with the
//   pump index and both Hall sensor levels. Each tick returns exactly one
//   transfer on the m_ channel: the pump index, a flag set when a measurement
//   or a timeout produced a new speed, and the pump's stored signed speed in
//   hundredths of RPM.
//   Flow: an accepted tick is evaluated against its pump's state; a tick that
//   completes a measurement then starts the shared restoring divider, which
//   resolves one quotient bit a cycle for 23 bits, before the result is loaded
//   into the output register. One tick is in flight at a time, so a new tick
//   is taken only after the last one has been loaded into the output register.
//   The result sits in an output register: s_ready comes back while a result
//   waits, and a stalled receiver holds off only the next tick's finish.
//   Reset (aresetn low, synchronous) clears all per-pump state to zero and the
//   configuration to timeout 500 ticks, 10 ms per tick, reverse mask 2.
//   The user must write configuration through the APB port while no tick is in flight; the block has no check.
module hall_pump_speed_gauge_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Tick input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hpsg_pkg::PUMP_W-1:0]         s_pump,
    input  logic                                s_hall_a,
    input  logic                                s_hall_b,
    // Result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hpsg_pkg::PUMP_W-1:0]         m_pump_echo,
    output logic                                m_new_value,
    output logic signed [hpsg_pkg::SPEED_W-1:0] m_speed_rpm_x100,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpsg_pkg::ADDR_W-1:0]         paddr,
    input  logic [hpsg_pkg::DATA_W-1:0]         pwdata,
    output logic [hpsg_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import hpsg_pkg::*;

`include "hall_pump_speed_gauge_top_defines.svh"

    cfg_t cfg;

    gauge_state_t state_reg, state_next;

    // Latched tick
    logic [PUMP_W-1:0] pump_reg;
    logic              hall_a_reg;
    logic              hall_b_reg;

    // Per-pump state
    logic               prev_a_reg  [NUM_PUMPS];
    logic               prev_b_reg  [NUM_PUMPS];
    logic [CNT_W-1:0]   cnt_a_reg   [NUM_PUMPS];
    logic [CNT_W-1:0]   cnt_b_reg   [NUM_PUMPS];
    logic [TICK_W-1:0]  tick_reg    [NUM_PUMPS];
    logic [TICK_W-1:0]  ab_reg      [NUM_PUMPS];
    logic [TICK_W-1:0]  ba_reg      [NUM_PUMPS];
    logic [SPEED_W-1:0] speed_reg   [NUM_PUMPS];

    // Result staging and output register
    logic               fresh_reg,  fresh_next;
    logic [SPEED_W-1:0] res_reg,    res_next;
    logic               neg_reg;
    logic               m_valid_reg;
    logic [PUMP_W-1:0]  m_pump_reg;
    logic               m_new_reg;
    logic [SPEED_W-1:0] m_speed_reg;

    // Tick evaluation
    logic               in_range;
    logic               a_fall, b_fall, edge_hit;
    logic [TICK_W-1:0]  tick_inc, tick_up;
    logic [CNT_W-1:0]   cnt_a_up, cnt_b_up;
    logic               timeout_hit, measure_hit, clear_hit;

    // Speed arithmetic
    logic [TICK_W:0]          sum_ticks;
    logic [DEN_W-2:0]         prod;
    logic [DEN_W-1:0]         den;
    logic                     rev, neg_next;
    logic                     div_start, div_done;
    logic [QUO_W-1:0]         quo;
    logic [SPEED_W-2:0]       mag;
    logic [SPEED_W-1:0]       speed_calc;

    logic eval_wr, div_wr, out_free;

    hpsg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (den),
        .done     (div_done),
        .quotient (quo)
    );

    // Evaluate the tick against the selected pump's state
    assign in_range    = {1'b0, pump_reg} < (PUMP_W + 1)'(NUM_PUMPS);
    assign tick_inc    = (tick_reg[pump_reg] == TICK_MAX) ? tick_reg[pump_reg]
                                                          : tick_reg[pump_reg] + 1'b1;
    assign a_fall      = (hall_a_reg != prev_a_reg[pump_reg]) && !hall_a_reg;
    assign b_fall      = !a_fall && (hall_b_reg != prev_b_reg[pump_reg]) && !hall_b_reg;
    assign edge_hit    = a_fall || b_fall;
    assign tick_up     = edge_hit ? '0 : tick_inc;
    assign cnt_a_up    = (a_fall && cnt_a_reg[pump_reg] != CNT_MAX)
                         ? cnt_a_reg[pump_reg] + 1'b1 : cnt_a_reg[pump_reg];
    assign cnt_b_up    = (b_fall && cnt_b_reg[pump_reg] != CNT_MAX)
                         ? cnt_b_reg[pump_reg] + 1'b1 : cnt_b_reg[pump_reg];
    assign timeout_hit = tick_up >= cfg.timeout_ticks;
    assign measure_hit = !timeout_hit
                         && (((cnt_a_up == CNT_W'(2)) && (cnt_b_up == CNT_W'(1)))
                          || ((cnt_a_up == CNT_W'(1)) && (cnt_b_up == CNT_W'(2))));
    assign clear_hit   = timeout_hit || measure_hit;

    // Denominator and sign from the stored intervals
    assign sum_ticks = {1'b0, ba_reg[pump_reg]} + {1'b0, ab_reg[pump_reg]};
    assign prod      = (DEN_W-1)'(sum_ticks) * (DEN_W-1)'(cfg.tick_period_ms);
    assign den       = {prod, 1'b0};
    assign rev       = cfg.reverse_mask[pump_reg];
    always_comb begin
        if (cfg.tick_period_ms == '0) begin
            neg_next = 1'b1;
        end else if (rev) begin
            neg_next = ba_reg[pump_reg] <= ab_reg[pump_reg];
        end else begin
            neg_next = ba_reg[pump_reg] >= ab_reg[pump_reg];
        end
    end

    // Saturate the quotient and apply the sign
    assign mag        = (quo > QUO_W'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_W-2:0];
    assign speed_calc = neg_reg ? SPEED_W'(0) - {1'b0, mag} : {1'b0, mag};

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_EVAL;
            ST_EVAL: state_next = (in_range && measure_hit) ? ST_MULT : ST_DONE;
            ST_MULT: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        eval_wr   = 1'b0;
        div_wr    = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_EVAL: eval_wr   = in_range;
            ST_MULT: div_start = 1'b1;
            ST_DIV:  div_wr    = div_done;
            ST_DONE: ;
            default: ;
        endcase
    end

    // Stage the result fields
    always_comb begin
        fresh_next = fresh_reg;
        res_next   = res_reg;
        if (state_reg == ST_EVAL) begin
            fresh_next = in_range && clear_hit;
            if (!in_range || timeout_hit) begin
                res_next = '0;
            end else begin
                res_next = speed_reg[pump_reg];
            end
        end else if (div_wr) begin
            res_next = speed_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture tick, stage result, load output
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pump_reg   <= s_pump;
            hall_a_reg <= s_hall_a;
            hall_b_reg <= s_hall_b;
        end
        if (div_start) begin
            neg_reg <= neg_next;
        end
        fresh_reg <= fresh_next;
        res_reg   <= res_next;
        if (state_reg == ST_DONE && out_free) begin
            m_pump_reg  <= pump_reg;
            m_new_reg   <= fresh_reg;
            m_speed_reg <= res_reg;
        end
    end

    // Per-pump state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PUMPS; i++) begin
                prev_a_reg[i] <= 1'b0;
                prev_b_reg[i] <= 1'b0;
                cnt_a_reg[i]  <= '0;
                cnt_b_reg[i]  <= '0;
                tick_reg[i]   <= '0;
                ab_reg[i]     <= '0;
                ba_reg[i]     <= '0;
                speed_reg[i]  <= '0;
            end
        end else if (eval_wr) begin
            prev_a_reg[pump_reg] <= hall_a_reg;
            if (!a_fall) begin
                prev_b_reg[pump_reg] <= hall_b_reg;
            end
            if (a_fall) begin
                ba_reg[pump_reg] <= tick_inc;
            end
            if (b_fall) begin
                ab_reg[pump_reg] <= tick_inc;
            end
            cnt_a_reg[pump_reg] <= clear_hit ? '0 : cnt_a_up;
            cnt_b_reg[pump_reg] <= clear_hit ? '0 : cnt_b_up;
            tick_reg[pump_reg]  <= clear_hit ? '0 : tick_up;
            if (timeout_hit) begin
                speed_reg[pump_reg] <= '0;
            end
        end else if (div_wr) begin
            speed_reg[pump_reg] <= speed_calc;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pump_echo      = m_pump_reg;
    assign m_new_value      = m_new_reg;
    assign m_speed_rpm_x100 = m_speed_reg;

    `HPSG_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "tick accepted while busy")
    `HPSG_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == ST_DIV, "divider finished out of turn")
    `HPSG_ASSERT_NEXT(a_done_loads_out, (state_reg == ST_DONE) && out_free, m_valid && (state_reg == ST_IDLE), "result not delivered")

endmodule

>>> rtl/core/hpsg_regs.sv
// APB configuration registers of the hall pump speed gauge.
// Depends on hpsg_pkg for widths, reset values and register indexes.
module hpsg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hpsg_pkg::ADDR_W-1:0] paddr,
    input  logic [hpsg_pkg::DATA_W-1:0] pwdata,
    output logic [hpsg_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output hpsg_pkg::cfg_t            cfg
);
    import hpsg_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks  <= TIMEOUT_RST;
            cfg_reg.tick_period_ms <= PERIOD_RST;
            cfg_reg.reverse_mask   <= MASK_RST;
        end else if (wr_en) begin
            case (idx)
                REG_TIMEOUT: cfg_reg.timeout_ticks  <= pwdata[TIMEOUT_W-1:0];
                REG_PERIOD:  cfg_reg.tick_period_ms <= pwdata[PERIOD_W-1:0];
                REG_REVERSE: cfg_reg.reverse_mask   <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        prdata = '0;
        case (idx)
            REG_TIMEOUT: prdata = DATA_W'(cfg_reg.timeout_ticks);
            REG_PERIOD:  prdata = DATA_W'(cfg_reg.tick_period_ms);
            REG_REVERSE: prdata = DATA_W'(cfg_reg.reverse_mask);
            default:     prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/hpsg_div.sv
// Restoring divider: fixed RPM scale divided by a measured denominator, one bit a cycle.
// Depends on hpsg_pkg for operand widths and the dividend constant.
module hpsg_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [hpsg_pkg::DEN_W-1:0] divisor,
    output logic                       done,
    output logic [hpsg_pkg::QUO_W-1:0] quotient
);
    import hpsg_pkg::*;

    logic [DCNT_W-1:0] cnt_reg,  cnt_next;
    logic              done_reg, done_next;
    logic [QUO_W-1:0]  dvd_reg,  dvd_next;
    logic [DEN_W-1:0]  rem_reg,  rem_next;
    logic [DEN_W-1:0]  dsr_reg,  dsr_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    // Shift in the next dividend bit and try one subtraction
    assign trial = {rem_reg, dvd_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = DCNT_W'(QUO_W);
            dvd_next = RPM_SCALE;
            rem_next = '0;
            dsr_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DEN_W]) begin
                rem_next = diff[DEN_W-1:0];
                dvd_next = {dvd_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                dvd_next = {dvd_reg[QUO_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath holds no reset
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> verif/hpsg_speed_monitor.sv
// Monitor and scoreboard for the hall pump speed gauge: mirrors the tick and register traffic,
// predicts every result transfer and compares it field by field. Depends on hpsg_pkg.
module hpsg_speed_monitor
    import hpsg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [PUMP_W-1:0]         s_pump,
    input  logic                      s_hall_a,
    input  logic                      s_hall_b,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [PUMP_W-1:0]         m_pump_echo,
    input  logic                      m_new_value,
    input  logic signed [SPEED_W-1:0] m_speed_rpm_x100,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    input  logic [DATA_W-1:0]         prdata,
    input  logic                      pready,
    output int                        fail_count,
    output int                        outstanding
);

    localparam logic [31:0] RPM_NUMERATOR = 32'd6000000;
    localparam logic [31:0] SPEED_LIMIT   = 32'd32767;

    typedef struct packed {
        logic [PUMP_W-1:0]         pump;
        logic                      fresh;
        logic signed [SPEED_W-1:0] speed;
    } speed_report_t;

    // Mirrored configuration and per-pump tachometer state
    cfg_t                      cfg;
    logic                      last_a      [NUM_PUMPS];
    logic                      last_b      [NUM_PUMPS];
    logic [CNT_W-1:0]          falls_a     [NUM_PUMPS];
    logic [CNT_W-1:0]          falls_b     [NUM_PUMPS];
    logic [TICK_W-1:0]         ticks_since [NUM_PUMPS];
    logic [TICK_W-1:0]         gap_ab      [NUM_PUMPS];
    logic [TICK_W-1:0]         gap_ba      [NUM_PUMPS];
    logic signed [SPEED_W-1:0] speed_now   [NUM_PUMPS];
    speed_report_t             report_q    [$];

    // Signed speed from the last two intervals, saturated, sign from interval order
    function automatic logic signed [SPEED_W-1:0] speed_from_gaps(input int p);
        logic [31:0]               ba_ms;
        logic [31:0]               ab_ms;
        logic [31:0]               den;
        logic [31:0]               mag;
        logic                      negate;
        logic signed [SPEED_W-1:0] speed;
        ba_ms = 32'(gap_ba[p]) * 32'(cfg.tick_period_ms);
        ab_ms = 32'(gap_ab[p]) * 32'(cfg.tick_period_ms);
        den   = 32'd2 * (ba_ms + ab_ms);
        mag   = (den == 32'd0) ? SPEED_LIMIT : RPM_NUMERATOR / den;
        if (mag > SPEED_LIMIT) begin
            mag = SPEED_LIMIT;
        end
        negate = cfg.reverse_mask[p] ? (ba_ms <= ab_ms) : (ba_ms >= ab_ms);
        speed  = mag[SPEED_W-1:0];
        if (negate) begin
            speed = -speed;
        end
        return speed;
    endfunction

    // Advance one pump by one tick and form the result it produces
    task automatic tick_pump(input int p, input logic a, input logic b,
                             output speed_report_t r);
        logic fell_a;
        logic fell_b;
        fell_a = 1'b0;
        fell_b = 1'b0;
        if (ticks_since[p] != TICK_MAX) begin
            ticks_since[p]++;
        end
        // B is looked at only when A did not fall on this tick
        if (a != last_a[p]) begin
            last_a[p] = a;
            fell_a    = !a;
        end
        if (fell_a) begin
            gap_ba[p]      = ticks_since[p];
            ticks_since[p] = '0;
            if (falls_a[p] != CNT_MAX) begin
                falls_a[p]++;
            end
        end else begin
            if (b != last_b[p]) begin
                last_b[p] = b;
                fell_b    = !b;
            end
            if (fell_b) begin
                gap_ab[p]      = ticks_since[p];
                ticks_since[p] = '0;
                if (falls_b[p] != CNT_MAX) begin
                    falls_b[p]++;
                end
            end
        end
        r.fresh = 1'b0;
        if (32'(ticks_since[p]) >= 32'(cfg.timeout_ticks)) begin
            speed_now[p]   = '0;
            falls_a[p]     = '0;
            falls_b[p]     = '0;
            ticks_since[p] = '0;
            r.fresh        = 1'b1;
        end else if ((falls_a[p] == 8'd2 && falls_b[p] == 8'd1) ||
                     (falls_a[p] == 8'd1 && falls_b[p] == 8'd2)) begin
            speed_now[p]   = speed_from_gaps(p);
            falls_a[p]     = '0;
            falls_b[p]     = '0;
            ticks_since[p] = '0;
            r.fresh        = 1'b1;
        end
        r.pump  = PUMP_W'(p);
        r.speed = speed_now[p];
    endtask

    always @(posedge aclk) begin : watch
        speed_report_t want;
        speed_report_t got;
        logic [DATA_W-1:0] reg_value;
        if (!aresetn) begin
            cfg.timeout_ticks  = TIMEOUT_RST;
            cfg.tick_period_ms = PERIOD_RST;
            cfg.reverse_mask   = MASK_RST;
            for (int p = 0; p < NUM_PUMPS; p++) begin
                last_a[p]      = 1'b0;
                last_b[p]      = 1'b0;
                falls_a[p]     = '0;
                falls_b[p]     = '0;
                ticks_since[p] = '0;
                gap_ab[p]      = '0;
                gap_ba[p]      = '0;
                speed_now[p]   = '0;
            end
            report_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end else begin
            // Track register writes and check read data
            if (psel && penable && pready) begin
                reg_value = '0;
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_TIMEOUT: begin
                        if (pwrite) cfg.timeout_ticks = pwdata[TIMEOUT_W-1:0];
                        reg_value = DATA_W'(cfg.timeout_ticks);
                    end
                    REG_PERIOD: begin
                        if (pwrite) cfg.tick_period_ms = pwdata[PERIOD_W-1:0];
                        reg_value = DATA_W'(cfg.tick_period_ms);
                    end
                    REG_REVERSE: begin
                        if (pwrite) cfg.reverse_mask = pwdata[MASK_W-1:0];
                        reg_value = DATA_W'(cfg.reverse_mask);
                    end
                    default: reg_value = prdata;
                endcase
                if (!pwrite && prdata !== reg_value) begin
                    $display("%0t: register at 0x%0h read expected 0x%0h, got 0x%0h",
                             $time, paddr, reg_value, prdata);
                    fail_count++;
                end
            end

            // Predict on every accepted tick
            if (s_valid && s_ready) begin
                tick_pump(int'(s_pump), s_hall_a, s_hall_b, want);
                report_q.push_back(want);
            end

            // Compare each result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                got.pump  = m_pump_echo;
                got.fresh = m_new_value;
                got.speed = m_speed_rpm_x100;
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got pump %0d",
                             $time, got.pump);
                    fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (got.pump !== want.pump) begin
                        $display("%0t: pump_echo expected %0d, got %0d",
                                 $time, want.pump, got.pump);
                        fail_count++;
                    end
                    if (got.fresh !== want.fresh) begin
                        $display("%0t: pump %0d new_value expected %0d, got %0d",
                                 $time, want.pump, want.fresh, got.fresh);
                        fail_count++;
                    end
                    if (got.speed !== want.speed) begin
                        $display("%0t: pump %0d speed expected %0d, got %0d",
                                 $time, want.pump, want.speed, got.speed);
                        fail_count++;
                    end
                end
            end
            outstanding = report_q.size();
        end
    end

endmodule

>>> verif/tb.sv
// Top of the hall pump speed gauge testbench: clock, reset, tick and register stimulus,
// receiver back-pressure and the verdict. Depends on hpsg_pkg, hpsg_speed_monitor and the RTL.
module tb;
    import hpsg_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;

    typedef enum {
        DRAIN_ALWAYS,
        DRAIN_MOSTLY,
        DRAIN_EVERY_FOURTH,
        DRAIN_COIN
    } drain_style_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [PUMP_W-1:0]         s_pump;
    logic                      s_hall_a;
    logic                      s_hall_b;
    logic                      m_valid;
    logic                      m_ready;
    logic [PUMP_W-1:0]         m_pump_echo;
    logic                      m_new_value;
    logic signed [SPEED_W-1:0] m_speed_rpm_x100;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    int                        fail_count;
    int                        outstanding;

    // Sender pacing, receiver hold-off request and per-pump rotor model
    int   cycles = 0;
    int   burst_left;
    int   gap_max;
    bit   hold_req;
    logic rot_a    [NUM_PUMPS];
    logic rot_b    [NUM_PUMPS];
    bit   rot_fwd  [NUM_PUMPS];
    int   rot_wait [NUM_PUMPS];

    hall_pump_speed_gauge_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pump           (s_pump),
        .s_hall_a         (s_hall_a),
        .s_hall_b         (s_hall_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pump_echo      (m_pump_echo),
        .m_new_value      (m_new_value),
        .m_speed_rpm_x100 (m_speed_rpm_x100),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    hpsg_speed_monitor u_speed_monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pump           (s_pump),
        .s_hall_a         (s_hall_a),
        .s_hall_b         (s_hall_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pump_echo      (m_pump_echo),
        .m_new_value      (m_new_value),
        .m_speed_rpm_x100 (m_speed_rpm_x100),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // End the run if it hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stall pattern in segments, plus one long hold-off on request
    initial begin : receiver
        int           seg_left;
        int           hold_left;
        drain_style_t style;
        seg_left  = 0;
        hold_left = 0;
        style     = DRAIN_ALWAYS;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold_left == 0) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(4, 60);
                    style    = drain_style_t'($urandom_range(0, 3));
                end
                seg_left--;
                case (style)
                    DRAIN_ALWAYS:       m_ready <= 1'b1;
                    DRAIN_MOSTLY:       m_ready <= ($urandom_range(0, 3) != 0);
                    DRAIN_EVERY_FOURTH: m_ready <= (seg_left % 4 == 0);
                    default:            m_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Offer one tick, opening a new burst after a random gap when the last one ran out
    task automatic send_tick(input int p, input logic a, input logic b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        rot_a[p] = a;
        rot_b[p] = b;
        s_valid  <= 1'b1;
        s_pump   <= PUMP_W'(p);
        s_hall_a <= a;
        s_hall_b <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random ticks: mostly quadrature rotation with random dwell, some sensor noise
    task automatic spin_pumps(input int count, input int hold_max);
        int   p;
        logic a;
        logic b;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, NUM_PUMPS - 1);
            a = rot_a[p];
            b = rot_b[p];
            if ($urandom_range(0, 99) < 12) begin
                a = 1'($urandom_range(0, 1));
                b = 1'($urandom_range(0, 1));
            end else if (rot_wait[p] > 0) begin
                rot_wait[p]--;
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    rot_fwd[p] = !rot_fwd[p];
                end
                // Forward walks 00,10,11,01; reverse walks the other way
                if ((a == b) == rot_fwd[p]) a = !a;
                else                        b = !b;
                rot_wait[p] = $urandom_range(0, hold_max);
            end
            send_tick(p, a, b);
        end
    endtask

    // Toggle only sensor A long enough to pin its edge count at the top, then one B edge
    task automatic spin_one_sensor(input int p, input int count);
        for (int i = 0; i < count; i++) begin
            send_tick(p, !rot_a[p], rot_b[p]);
        end
        if (!rot_b[p]) begin
            send_tick(p, rot_a[p], 1'b1);
        end
        send_tick(p, rot_a[p], 1'b0);
    endtask

    task automatic reg_access(input reg_idx_t idx, input logic wr, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_config();
        reg_access(REG_TIMEOUT, 1'b0, '0);
        reg_access(REG_PERIOD, 1'b0, '0);
        reg_access(REG_REVERSE, 1'b0, '0);
    endtask

    task automatic set_config(input int timeout, input int period, input int mask);
        reg_access(REG_TIMEOUT, 1'b1, DATA_W'(timeout));
        reg_access(REG_PERIOD, 1'b1, DATA_W'(period));
        reg_access(REG_REVERSE, 1'b1, DATA_W'(mask));
        read_config();
    endtask

    // Drop valid, wait for every predicted result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_pump   <= '0;
        s_hall_a <= 1'b0;
        s_hall_b <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        hold_req   = 1'b0;
        burst_left = 0;
        gap_max    = 8;
        for (int p = 0; p < NUM_PUMPS; p++) begin
            rot_a[p]    = 1'b0;
            rot_b[p]    = 1'b0;
            rot_fwd[p]  = 1'($urandom_range(0, 1));
            rot_wait[p] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values, then hand-picked ticks
        read_config();
        // pump 0: A, B, A falls two ticks apart, magnitude saturates
        send_tick(0, 1'b1, 1'b0);
        send_tick(0, 1'b0, 1'b0);
        send_tick(0, 1'b0, 1'b1);
        send_tick(0, 1'b0, 1'b0);
        send_tick(0, 1'b1, 1'b0);
        send_tick(0, 1'b0, 1'b0);
        // pump 1 (reverse bit set): both fall together, B is only seen next tick
        send_tick(1, 1'b1, 1'b1);
        send_tick(1, 1'b0, 1'b0);
        send_tick(1, 1'b0, 1'b0);
        send_tick(1, 1'b1, 1'b1);
        send_tick(1, 1'b0, 1'b1);
        // pump 3: one A fall then two B falls
        send_tick(3, 1'b1, 1'b1);
        send_tick(3, 1'b0, 1'b1);
        send_tick(3, 1'b0, 1'b1);
        send_tick(3, 1'b0, 1'b0);
        send_tick(3, 1'b0, 1'b1);
        send_tick(3, 1'b0, 1'b0);
        send_tick(2, 1'b1, 1'b1);
        spin_pumps(40, 1);
        drain();

        // Short timeout, one millisecond per tick, no reversed pumps
        set_config(5, 1, 0);
        spin_pumps(30, 12);
        drain();

        // Largest timeout, all pumps reversed; edge count saturation, then a stretch with no sender gaps
        set_config(65535, 100, 15);
        spin_one_sensor(2, 520);
        gap_max = 0;
        spin_pumps(20, 2);
        gap_max = 8;
        drain();

        // Zero timeout: every tick clears the speed
        set_config(0, 50, 5);
        spin_pumps(10, 6);
        drain();

        // Zero tick period: measurements hit the zero denominator
        set_config(200, 0, 9);
        spin_pumps(30, 1);
        drain();

        // Random settings with a long receiver hold-off to fill the block
        set_config($urandom_range(20, 600), $urandom_range(1, 100), $urandom_range(0, 15));
        hold_req = 1'b1;
        spin_pumps(30, 3);
        drain();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
